// ----- hw/rtl/ulit_pkg.sv -----
// ----------------------------------------------------------------------------
// ulit_pkg
// Shared constants, command and status codes, and the control and status
// bundles between the list controller and its datapath.
// ----------------------------------------------------------------------------
package ulit_pkg;

   localparam int DEPTH       = 64;
   localparam int ITEM_WIDTH  = 32;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);

   localparam int CMD_W       = 3;
   localparam int ITEM_IN_W   = 32;
   localparam int ITEM_OUT_W  = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 7;

   localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RETRIEVE   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_MAKE_EMPTY = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RESET_ITER = 3'd4;
   localparam logic [CMD_W-1:0] CMD_GET_NEXT   = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic                capture;
      logic                insert;
      logic                clear_list;
      logic                clear_iter;
      logic                iter_advance;
      logic                scan_start;
      logic                scan_next;
      logic                shift_start;
      logic                shift_next;
      logic                count_dec;
      logic                res_load;
      logic                res_from_ram;
      logic [STATUS_W-1:0] res_status;
      logic                out_load;
   } dp_ctrl_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             count_zero;
      logic             full;
      logic             hit;
      logic             at_bottom;
      logic             at_last;
      logic             out_free;
   } dp_stat_type;

endpackage

// ----- hw/rtl/ulit_if.sv -----
// ----------------------------------------------------------------------------
// ulit_req_if / ulit_rsp_if
// Valid/ready channels carrying list commands and their results.
// ----------------------------------------------------------------------------
interface ulit_req_if import ulit_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [ITEM_IN_W-1:0] item_in;

   modport source (output valid, output cmd, output item_in, input ready);
   modport sink   (input valid, input cmd, input item_in, output ready);
endinterface

interface ulit_rsp_if import ulit_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [ITEM_OUT_W-1:0]  item_out;
   logic [STATUS_W-1:0]    status;
   logic [COUNT_OUT_W-1:0] item_count;
   logic                   is_full;

   modport source (output valid, output item_out, output status, output item_count,
                   output is_full, input ready);
   modport sink   (input valid, input item_out, input status, input item_count,
                   input is_full, output ready);
endinterface

// ----- hw/rtl/ulit_ram.sv -----
// ----------------------------------------------------------------------------
// ulit_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ulit_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/ulit_datapath.sv -----
// ----------------------------------------------------------------------------
// ulit_datapath
// Entry storage, count, iterator, scan pointer and the result register.
// ----------------------------------------------------------------------------
module ulit_datapath import ulit_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_ctrl_type            ctrl,
   output dp_stat_type            stat,
   input  logic [CMD_W-1:0]       req_cmd,
   input  logic [ITEM_IN_W-1:0]   req_item_in,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [ITEM_OUT_W-1:0]  rsp_item_out,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [COUNT_OUT_W-1:0] rsp_item_count,
   output logic                   rsp_is_full
);

   logic [CMD_W-1:0]       cmd_ff, cmd_in;
   logic [ITEM_WIDTH-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [ADDR_W-1:0]      iter_index_ff, iter_index_in;
   logic                   iter_started_ff, iter_started_in;
   logic [ADDR_W-1:0]      ptr_ff, ptr_in;
   logic [ITEM_WIDTH-1:0]  res_item_ff, res_item_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic                   out_valid_ff, out_valid_in;
   logic [ITEM_OUT_W-1:0]  out_item_ff, out_item_in;
   logic [STATUS_W-1:0]    out_status_ff, out_status_in;
   logic [COUNT_OUT_W-1:0] out_count_ff, out_count_in;
   logic                   out_full_ff, out_full_in;

   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ITEM_WIDTH-1:0]  wr_data;
   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic [ITEM_WIDTH-1:0]  rd_data;

   logic [ADDR_W-1:0]      last_addr;
   logic [CNT_W-1:0]       iter_step;
   logic [CNT_W-1:0]       iter_next;
   logic [ADDR_W-1:0]      iter_addr;
   logic                   is_full;

   ulit_ram #(
      .WIDTH (ITEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign last_addr = ADDR_W'(count_ff - CNT_W'(1));
   assign is_full   = (count_ff == CNT_W'(DEPTH));

   // iterator position counted from the newest entry
   always_comb begin
      iter_step = iter_started_ff ? (CNT_W'(iter_index_ff) + CNT_W'(1)) : '0;
      iter_next = (iter_step >= count_ff) ? '0 : iter_step;
      iter_addr = ADDR_W'(count_ff - CNT_W'(1) - iter_next);
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ADDR_W'(count_ff);
      wr_data = key_ff;
      rd_en   = 1'b0;
      rd_addr = ptr_ff;
      ptr_in  = ptr_ff;
      if (ctrl.insert) begin
         wr_en = 1'b1;
      end
      if (ctrl.scan_start) begin
         rd_en   = 1'b1;
         rd_addr = last_addr;
         ptr_in  = last_addr;
      end
      if (ctrl.scan_next) begin
         rd_en   = 1'b1;
         rd_addr = ptr_ff - ADDR_W'(1);
         ptr_in  = ptr_ff - ADDR_W'(1);
      end
      if (ctrl.shift_start || ctrl.shift_next) begin
         rd_en   = 1'b1;
         rd_addr = ptr_ff + ADDR_W'(1);
         ptr_in  = ptr_ff + ADDR_W'(1);
      end
      if (ctrl.shift_next) begin
         wr_en   = 1'b1;
         wr_addr = ptr_ff - ADDR_W'(1);
         wr_data = rd_data;
      end
      if (ctrl.iter_advance) begin
         rd_en   = 1'b1;
         rd_addr = iter_addr;
      end
   end

   always_comb begin
      cmd_in          = ctrl.capture ? req_cmd : cmd_ff;
      key_in          = ctrl.capture ? ITEM_WIDTH'(req_item_in) : key_ff;
      count_in        = count_ff;
      iter_index_in   = iter_index_ff;
      iter_started_in = iter_started_ff;
      if (ctrl.clear_list) begin
         count_in = '0;
      end else if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.count_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (ctrl.clear_iter) begin
         iter_index_in   = '0;
         iter_started_in = 1'b0;
      end else if (ctrl.iter_advance) begin
         iter_index_in   = ADDR_W'(iter_next);
         iter_started_in = 1'b1;
      end
   end

   always_comb begin
      res_item_in   = res_item_ff;
      res_status_in = res_status_ff;
      if (ctrl.res_load) begin
         res_item_in   = ctrl.res_from_ram ? rd_data : '0;
         res_status_in = ctrl.res_status;
      end
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_item_in   = out_item_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      out_full_in   = out_full_ff;
      if (ctrl.out_load) begin
         out_valid_in  = 1'b1;
         out_item_in   = ITEM_OUT_W'(res_item_ff);
         out_status_in = res_status_ff;
         out_count_in  = COUNT_OUT_W'(count_ff);
         out_full_in   = is_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= '0;
         iter_index_ff   <= '0;
         iter_started_ff <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         count_ff        <= count_in;
         iter_index_ff   <= iter_index_in;
         iter_started_ff <= iter_started_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      ptr_ff        <= ptr_in;
      res_item_ff   <= res_item_in;
      res_status_ff <= res_status_in;
      out_item_ff   <= out_item_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
      out_full_ff   <= out_full_in;
   end

   assign stat.cmd        = cmd_ff;
   assign stat.count_zero = (count_ff == '0);
   assign stat.full       = is_full;
   assign stat.hit        = (rd_data == key_ff);
   assign stat.at_bottom  = (ptr_ff == '0);
   assign stat.at_last    = (ptr_ff == last_addr);
   assign stat.out_free   = !out_valid_ff || rsp_ready;

   assign rsp_valid      = out_valid_ff;
   assign rsp_item_out   = out_item_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_item_count = out_count_ff;
   assign rsp_is_full    = out_full_ff;

endmodule

// ----- hw/rtl/ulit_ctrl.sv -----
// ----------------------------------------------------------------------------
// ulit_ctrl
// Command sequencer: dispatch, newest-first search, compaction after delete,
// iterator read and result hand-off.
// ----------------------------------------------------------------------------
module ulit_ctrl import ulit_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_ctrl_type ctrl
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_SHIFT    = 3'd3;
   localparam logic [2:0] S_READ     = 3'd4;
   localparam logic [2:0] S_DONE     = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      ctrl     = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.capture = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            ctrl.res_load   = 1'b1;
            ctrl.res_status = ST_OK;
            state_in        = S_DONE;
            unique case (stat.cmd)
               CMD_INSERT: begin
                  if (stat.full) begin
                     ctrl.res_status = ST_FULL;
                  end else begin
                     ctrl.insert = 1'b1;
                  end
               end
               CMD_DELETE, CMD_RETRIEVE: begin
                  if (stat.count_zero) begin
                     ctrl.res_status = ST_NOT_FOUND;
                  end else begin
                     ctrl.res_load   = 1'b0;
                     ctrl.scan_start = 1'b1;
                     state_in        = S_SCAN;
                  end
               end
               CMD_MAKE_EMPTY: begin
                  ctrl.clear_list = 1'b1;
                  ctrl.clear_iter = 1'b1;
               end
               CMD_RESET_ITER: begin
                  ctrl.clear_iter = 1'b1;
               end
               CMD_GET_NEXT: begin
                  if (stat.count_zero) begin
                     ctrl.res_status = ST_EMPTY;
                  end else begin
                     ctrl.res_load     = 1'b0;
                     ctrl.iter_advance = 1'b1;
                     state_in          = S_READ;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            if (stat.hit) begin
               if (stat.cmd == CMD_RETRIEVE) begin
                  ctrl.res_load     = 1'b1;
                  ctrl.res_from_ram = 1'b1;
                  ctrl.res_status   = ST_OK;
                  state_in          = S_DONE;
               end else if (stat.at_last) begin
                  ctrl.count_dec  = 1'b1;
                  ctrl.res_load   = 1'b1;
                  ctrl.res_status = ST_OK;
                  state_in        = S_DONE;
               end else begin
                  ctrl.shift_start = 1'b1;
                  state_in         = S_SHIFT;
               end
            end else if (stat.at_bottom) begin
               ctrl.res_load   = 1'b1;
               ctrl.res_status = ST_NOT_FOUND;
               state_in        = S_DONE;
            end else begin
               ctrl.scan_next = 1'b1;
            end
         end
         S_SHIFT: begin
            ctrl.shift_next = 1'b1;
            if (stat.at_last) begin
               ctrl.count_dec  = 1'b1;
               ctrl.res_load   = 1'b1;
               ctrl.res_status = ST_OK;
               state_in        = S_DONE;
            end
         end
         S_READ: begin
            ctrl.res_load     = 1'b1;
            ctrl.res_from_ram = 1'b1;
            ctrl.res_status   = ST_OK;
            state_in          = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               ctrl.out_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/unsorted_item_list_table.sv -----
// ----------------------------------------------------------------------------
// unsorted_item_list_table
// Bounded unsorted list of items with insert, delete, retrieve, make empty,
// iterator rewind and newest-to-oldest get next.
//
// req_port takes one command transaction (cmd, item_in); rsp_port returns
// exactly one result transaction per command (item_out, status, item_count,
// is_full), in command order. One command is worked on at a time.
// Retrieve and delete examine entries newest first, one per cycle through
// the RAM read port; delete then moves the entries above the match down,
// one per cycle, to close the gap. The next command is accepted in the cycle
// after its result is loaded into the output register, even while the
// receiver has not taken that result yet; a stalled result holds until taken.
// Reset clears the count and the iterator; entry storage is not cleared.
// ----------------------------------------------------------------------------
module unsorted_item_list_table import ulit_pkg::*; (
   input logic       clock,
   input logic       reset,
   ulit_req_if.sink  req_port,
   ulit_rsp_if.source rsp_port
);

   dp_ctrl_type ctrl;
   dp_stat_type stat;

   ulit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   ulit_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .stat           (stat),
      .req_cmd        (req_port.cmd),
      .req_item_in    (req_port.item_in),
      .rsp_ready      (rsp_port.ready),
      .rsp_valid      (rsp_port.valid),
      .rsp_item_out   (rsp_port.item_out),
      .rsp_status     (rsp_port.status),
      .rsp_item_count (rsp_port.item_count),
      .rsp_is_full    (rsp_port.is_full)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_port.valid && req_port.ready |=> !req_port.ready)
      else $error("command accepted while another is in progress");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid |-> (rsp_port.is_full == (rsp_port.item_count == COUNT_OUT_W'(DEPTH))))
      else $error("full flag disagrees with item count");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.status == ST_EMPTY
      |-> rsp_port.item_count == '0 && rsp_port.item_out == '0)
      else $error("empty status with entries held or nonzero item");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.status == ST_FULL |-> rsp_port.is_full)
      else $error("full status while list has room");

endmodule
